@@ rtl/core/trt_pkg.sv @@
`timescale 1ns / 1ps
package trt_pkg;

  localparam int unsigned DefaultEntries = 16;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_END   = 2'd1,
    KIND_RACE  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_NOT_FOUND = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] key_high;
    logic [63:0] key_low;
    logic [15:0] snap;
    logic [63:0] tok;
    logic [63:0] rights;
  } req_t;

  // token passed along the row of cells
  typedef struct packed {
    logic        go;
    logic        found;
    logic        free;
    logic        freed;
    logic [15:0] rc;
    logic [63:0] tok;
  } carry_t;

endpackage

@@ rtl/core/trt_cell.sv @@
`timescale 1ns / 1ps
module trt_cell (
  input  logic              clk,
  input  logic              rst,
  input  trt_pkg::req_t     req,
  input  logic              alloc,
  input  trt_pkg::carry_t   cin,
  output trt_pkg::carry_t   cout
);
  import trt_pkg::*;

  logic        valid;
  logic [63:0] key_high;
  logic [63:0] key_low;
  logic [15:0] active;
  logic [15:0] race;
  logic [63:0] mask;
  logic        claim;

  logic        match;
  logic        hit;
  logic        take;
  logic [15:0] active_dec;
  carry_t      cout_next;

  assign match      = valid && (key_high == req.key_high) && (key_low == req.key_low);
  assign hit        = cin.go && match && !cin.found;
  assign take       = cin.go && !valid && !cin.free;
  assign active_dec = active - 16'd1;

  always_comb begin
    cout_next       = cin;
    cout_next.found = cin.found | match;
    cout_next.free  = cin.free | !valid;
    if (hit) begin
      case (req.kind)
        KIND_START: cout_next.rc = race;
        KIND_END: begin
          if (req.snap != race) begin
            cout_next.tok = cin.tok & ~mask;
          end
          cout_next.freed = (active_dec == 16'd0);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      claim <= 1'b0;
      cout  <= '0;
    end else begin
      cout <= cout_next;
      if (cin.go) begin
        claim <= take;
      end
      if (hit) begin
        case (req.kind)
          KIND_START: active <= active + 16'd1;
          KIND_END: begin
            active <= active_dec;
            if (active_dec == 16'd0) begin
              valid <= 1'b0;
            end
          end
          KIND_RACE: begin
            mask <= mask | req.rights;
            race <= race + 16'd1;
          end
          default: ;
        endcase
      end
      if (alloc && claim) begin
        valid    <= 1'b1;
        claim    <= 1'b0;
        key_high <= req.key_high;
        key_low  <= req.key_low;
        active   <= 16'd1;
        race     <= 16'd0;
        mask     <= '0;
      end
    end
  end

endmodule

@@ rtl/core/token_race_tracker_unit.sv @@
`timescale 1ns / 1ps
// the request is registered, its token passes the registers of the row of cells, then the result is registered
// no new transaction is taken until the result has been taken
// the request token moves one cell per cycle; a new slot is written at the edge that registers the result
// reset clears every slot valid bit and all control state; slot contents stay undefined
module token_race_tracker_unit #(
  parameter int unsigned ENTRIES = trt_pkg::DefaultEntries
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [63:0] fid_high,
  input  logic [63:0] fid_low,
  input  logic [15:0] snapshot,
  input  logic [63:0] token_type,
  input  logic [63:0] rights,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [15:0] race_count,
  output logic [63:0] token_type_out,
  output logic        entry_freed
);
  import trt_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_OUT  = 3'b100
  } state_t;

  state_t state;
  req_t   req;
  logic   launch;
  logic   alloc;
  carry_t chain [ENTRIES+1];
  carry_t last;

  assign in_stall = (state != ST_IDLE);
  assign last     = chain[ENTRIES];
  assign alloc    = (state == ST_SCAN) && last.go && (req.kind == KIND_START)
                    && !last.found && last.free;

  always_comb begin
    chain[0]       = '0;
    chain[0].go    = launch;
    chain[0].tok   = req.tok;
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    trt_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .req   (req),
      .alloc (alloc),
      .cin   (chain[i]),
      .cout  (chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      launch    <= 1'b0;
    end else begin
      launch <= (state == ST_IDLE) && in_valid;
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            req.kind     <= kind;
            req.key_high <= fid_high;
            req.key_low  <= fid_low;
            req.snap     <= snapshot;
            req.tok      <= token_type;
            req.rights   <= rights;
            state        <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (last.go) begin
            status         <= STATUS_OK;
            race_count     <= 16'd0;
            token_type_out <= last.tok;
            entry_freed    <= 1'b0;
            case (req.kind)
              KIND_START: begin
                if (last.found) begin
                  race_count <= last.rc;
                end else if (!last.free) begin
                  status <= STATUS_FULL;
                end
              end
              KIND_END: begin
                if (!last.found) begin
                  status <= STATUS_NOT_FOUND;
                end else begin
                  entry_freed <= last.freed;
                end
              end
              KIND_RACE: begin
                if (!last.found) begin
                  status <= STATUS_NOT_FOUND;
                end
              end
              default: ;
            endcase
            out_valid <= 1'b1;
            state     <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_no_accept_with_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> !out_valid)
    else $error("input transaction accepted while result pending");

  a_done_in_scan: assert property (@(posedge clk) disable iff (rst)
    last.go |-> (state == ST_SCAN))
    else $error("scan token left the row outside a scan");

  a_result_after_scan: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_SCAN))
    else $error("result raised without a finished scan");

  a_alloc_then_out: assert property (@(posedge clk) disable iff (rst)
    alloc |=> (out_valid && status == STATUS_OK))
    else $error("slot allocation without ok result");

endmodule

@@ bench/token_race_tracker_unit_tb.sv @@
`timescale 1ns / 1ps
module token_race_tracker_unit_tb;
  import trt_pkg::*;

  localparam int unsigned Slots = DefaultEntries;
  localparam int unsigned PoolSize = 20;
  localparam int unsigned CycleLimit = 500000;
  localparam logic [1:0] KindUnused = 2'd3;
  localparam logic [63:0] AllOnes = '1;

  typedef struct {
    status_t     st;
    logic [15:0] rc;
    logic [63:0] tok;
    logic        freed;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  kind = '0;
  logic [63:0] fid_high = '0;
  logic [63:0] fid_low = '0;
  logic [15:0] snapshot = '0;
  logic [63:0] token_type = '0;
  logic [63:0] rights = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [15:0] race_count;
  logic [63:0] token_type_out;
  logic        entry_freed;

  // predicted table contents
  logic        tbl_valid [Slots];
  logic [63:0] tbl_hi [Slots];
  logic [63:0] tbl_lo [Slots];
  logic [15:0] tbl_users [Slots];
  logic [15:0] tbl_races [Slots];
  logic [63:0] tbl_mask [Slots];

  logic [63:0] pool_hi [PoolSize];
  logic [63:0] pool_lo [PoolSize];

  outcome_t pending_results[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;

  token_race_tracker_unit DUT (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= !rst && ($urandom_range(99) < recv_idle_pct);
  end

  function automatic int lookup_slot(logic [63:0] hi, logic [63:0] lo);
    for (int i = 0; i < Slots; i++) begin
      if (tbl_valid[i] && tbl_hi[i] == hi && tbl_lo[i] == lo) return i;
    end
    return -1;
  endfunction

  function automatic void apply_transaction(logic [1:0] k, logic [63:0] hi, logic [63:0] lo,
                                            logic [15:0] snap, logic [63:0] tok,
                                            logic [63:0] rts);
    outcome_t o;
    int s;
    o.st = STATUS_OK;
    o.rc = '0;
    o.tok = tok;
    o.freed = 1'b0;
    s = lookup_slot(hi, lo);
    case (k)
      KIND_START: begin
        if (s >= 0) begin
          tbl_users[s] = tbl_users[s] + 16'd1;
          o.rc = tbl_races[s];
        end else begin
          for (int i = 0; i < Slots; i++) begin
            if (!tbl_valid[i]) begin
              s = i;
              break;
            end
          end
          if (s < 0) begin
            o.st = STATUS_FULL;
          end else begin
            tbl_valid[s] = 1'b1;
            tbl_hi[s] = hi;
            tbl_lo[s] = lo;
            tbl_users[s] = 16'd1;
            tbl_races[s] = '0;
            tbl_mask[s] = '0;
          end
        end
      end
      KIND_END: begin
        if (s < 0) begin
          o.st = STATUS_NOT_FOUND;
        end else begin
          if (snap != tbl_races[s]) o.tok = tok & ~tbl_mask[s];
          tbl_users[s] = tbl_users[s] - 16'd1;
          if (tbl_users[s] == '0) begin
            tbl_valid[s] = 1'b0;
            o.freed = 1'b1;
          end
        end
      end
      KIND_RACE: begin
        if (s < 0) begin
          o.st = STATUS_NOT_FOUND;
        end else begin
          tbl_mask[s] = tbl_mask[s] | rts;
          tbl_races[s] = tbl_races[s] + 16'd1;
        end
      end
      default: ;
    endcase
    pending_results.push_back(o);
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  // result checker: a transaction completes at the next edge when valid and not stalled
  always @(negedge clk) begin
    outcome_t o;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing outstanding");
      end else begin
        o = pending_results.pop_front();
        if (status !== o.st)
          report_mismatch($sformatf("status %0d expected %0d", status, o.st));
        if (race_count !== o.rc)
          report_mismatch($sformatf("race_count %h expected %h", race_count, o.rc));
        if (token_type_out !== o.tok)
          report_mismatch($sformatf("token_type_out %h expected %h", token_type_out, o.tok));
        if (entry_freed !== o.freed)
          report_mismatch($sformatf("entry_freed %b expected %b", entry_freed, o.freed));
      end
    end
  end

  task automatic send_call(logic [1:0] k, logic [63:0] hi, logic [63:0] lo,
                           logic [15:0] snap, logic [63:0] tok, logic [63:0] rts);
    bit done;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    kind <= k;
    fid_high <= hi;
    fid_low <= lo;
    snapshot <= snap;
    token_type <= tok;
    rights <= rts;
    in_valid <= 1'b1;
    do begin
      @(negedge clk);
      done = !in_stall;
      if (done) apply_transaction(k, hi, lo, snap, tok, rts);
      @(posedge clk);
    end while (!done);
  endtask

  function automatic logic [63:0] rand_word();
    case ($urandom_range(9))
      0: return '0;
      1: return AllOnes;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [15:0] snap_for(int p);
    int s;
    s = lookup_slot(pool_hi[p], pool_lo[p]);
    if (s >= 0 && $urandom_range(3) != 0) return tbl_races[s];
    return 16'($urandom);
  endfunction

  task automatic test_race_lifecycle();
    send_call(KIND_START, pool_hi[0], pool_lo[0], '0, AllOnes, '0);
    send_call(KIND_START, pool_hi[1], pool_lo[1], AllOnes, '0, AllOnes);
    send_call(KIND_RACE, pool_hi[0], pool_lo[0], '0, '0, 64'h8000_0000_0000_0001);
    send_call(KIND_RACE, pool_hi[0], pool_lo[0], '0, '0, 64'h0000_ffff_0000_0000);
    send_call(KIND_START, pool_hi[0], pool_lo[0], '0, '0, '0);
    // stale snapshot trims, current one does not
    send_call(KIND_END, pool_hi[0], pool_lo[0], '0, AllOnes, '0);
    send_call(KIND_END, pool_hi[0], pool_lo[0], 16'd2, AllOnes, '0);
    send_call(KIND_END, pool_hi[0], pool_lo[0], 16'd2, AllOnes, '0);
    send_call(KIND_RACE, pool_hi[0], pool_lo[0], '0, '0, AllOnes);
  endtask

  task automatic test_partial_key_and_unused_kind();
    send_call(KIND_END, pool_hi[2], pool_lo[2], '0, 64'h1234_5678_9abc_def0, '0);
    send_call(KIND_RACE, pool_hi[3], pool_lo[3], '0, '0, AllOnes);
    send_call(KindUnused, pool_hi[1], pool_lo[1], AllOnes, AllOnes, AllOnes);
  endtask

  task automatic test_table_full();
    for (int p = 0; p < Slots; p++) send_call(KIND_START, pool_hi[p], pool_lo[p], '0, '0, '0);
    send_call(KIND_START, pool_hi[Slots], pool_lo[Slots], '0, AllOnes, '0);
  endtask

  task automatic test_random_traffic(int count);
    int p;
    int r;
    for (int n = 0; n < count; n++) begin
      p = $urandom_range(PoolSize - 1);
      r = $urandom_range(99);
      if ($urandom_range(19) == 0) begin
        send_call(2'($urandom), {$urandom, $urandom}, {$urandom, $urandom}, 16'($urandom),
                  rand_word(), rand_word());
      end else if (r < 40) begin
        send_call(KIND_START, pool_hi[p], pool_lo[p], 16'($urandom), rand_word(), rand_word());
      end else if (r < 74) begin
        send_call(KIND_END, pool_hi[p], pool_lo[p], snap_for(p), rand_word(), rand_word());
      end else if (r < 95) begin
        send_call(KIND_RACE, pool_hi[p], pool_lo[p], 16'($urandom), rand_word(), rand_word());
      end else begin
        send_call(KindUnused, pool_hi[p], pool_lo[p], 16'($urandom), rand_word(), rand_word());
      end
    end
  endtask

  initial begin
    for (int i = 0; i < Slots; i++) tbl_valid[i] = 1'b0;
    pool_hi[0] = '0;
    pool_lo[0] = '0;
    pool_hi[1] = AllOnes;
    pool_lo[1] = AllOnes;
    pool_hi[2] = AllOnes;
    pool_lo[2] = '0;
    pool_hi[3] = '0;
    pool_lo[3] = AllOnes;
    for (int p = 4; p < PoolSize; p++) begin
      pool_hi[p] = {$urandom, $urandom};
      pool_lo[p] = {$urandom, $urandom};
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 17;
    recv_idle_pct = 81;
    test_race_lifecycle();
    test_partial_key_and_unused_kind();
    test_table_full();
    test_random_traffic(530);
    send_idle_pct = 81;
    recv_idle_pct = 17;
    test_random_traffic(530);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(540);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (Slots + 4) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
